>>> rtl/bcu_pkg.sv
// Package for the branch condition unit: command codes, logic operation codes,
// move selectors and the item structures shared by the RTL.
// Depends on nothing.
package bcu_pkg;

   // Command codes carried in the command field.
   typedef enum logic [2:0] {
      CMD_BX         = 3'd0,
      CMD_BC         = 3'd1,
      CMD_BCLR       = 3'd2,
      CMD_BCCTR      = 3'd3,
      CMD_CR_LOGIC   = 3'd4,
      CMD_TRAP_DWORD = 3'd5,
      CMD_TRAP_WORD  = 3'd6,
      CMD_MOVE       = 3'd7
   } command_type;

   // Condition-bit logic operations.
   typedef enum logic [2:0] {
      LOP_AND  = 3'd0,
      LOP_ANDC = 3'd1,
      LOP_EQV  = 3'd2,
      LOP_NAND = 3'd3,
      LOP_NOR  = 3'd4,
      LOP_OR   = 3'd5,
      LOP_ORC  = 3'd6,
      LOP_XOR  = 3'd7
   } logic_op_type;

   // Register selectors for the move command (carried in bb).
   localparam logic [4:0] MOVE_LINK  = 5'd0;
   localparam logic [4:0] MOVE_COUNT = 5'd1;
   localparam logic [4:0] MOVE_COND  = 5'd2;

   // BO bit positions.
   localparam int unsigned BO_NO_COND  = 4;
   localparam int unsigned BO_COND_SET = 3;
   localparam int unsigned BO_NO_DEC   = 2;
   localparam int unsigned BO_CTR_ZERO = 1;

   // Trap mask bit positions.
   localparam int unsigned TO_SLT = 4;
   localparam int unsigned TO_SGT = 3;
   localparam int unsigned TO_EQ  = 2;
   localparam int unsigned TO_ULT = 1;
   localparam int unsigned TO_UGT = 0;

   localparam int unsigned REQ_DATA_WIDTH = 208;
   localparam int unsigned RSP_DATA_WIDTH = 200;

   // One input item, unpacked from the request stream.
   typedef struct packed {
      command_type         command;
      logic [31:0]         instr_address;
      logic signed [23:0]  offset_words;
      logic                absolute;
      logic                link;
      logic [4:0]          bo;
      logic [4:0]          bi;
      logic [4:0]          bb;
      logic_op_type        logic_op;
      logic [63:0]         operand_a;
      logic [63:0]         operand_b;
   } req_item_type;

   // One result item, before packing onto the response stream.
   typedef struct packed {
      logic        taken;
      logic [31:0] next_address;
      logic [63:0] link_value;
      logic [63:0] count_value;
      logic [31:0] cond_value;
      logic        trap;
   } rsp_item_type;

endpackage

>>> rtl/branch_condition_unit.sv
// Branch condition unit top level: input register, single-pass execute logic,
// architectural registers and the result register.
// Depends on bcu_pkg.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  req_tdata  (208 bits, one operation)
//  rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata  (200 bits, one result)
//
// Each operation passes through the input register, where it executes, and then
// the result register. A new operation is accepted every cycle unless the
// response stalls; the condition, count and link registers update as an
// operation leaves the input register.
// Reset is synchronous and clears the three registers and both valid flags.
// A stalled response holds the result register and then the input register.
module branch_condition_unit
   import bcu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // command[2:0], instr_address[34:3], offset_words[58:35], absolute[59],
   // link[60], bo[65:61], bi[70:66], bb[75:71], logic_op[78:76],
   // operand_a[142:79], operand_b[206:143], zero pad[207]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // taken[0], next_address[32:1], link_value[96:33], count_value[160:97],
   // cond_value[192:161], trap[193], zero pad[199:194]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   req_item_type item_ff, item_in;
   logic         item_valid_ff, item_valid_in;
   rsp_item_type result_ff, result_in;
   logic         result_valid_ff, result_valid_in;
   logic [31:0]  cond_ff, cond_in;
   logic [63:0]  count_ff, count_in;
   logic [63:0]  link_ff, link_in;

   logic         advance;
   logic         load;

   // Handshake: the input register moves on when the result register is free or being read.
   assign advance    = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   assign item_valid_in   = load ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign result_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : result_valid_ff);

   // Unpack the request transfer.
   always_comb begin
      item_in.command       = command_type'(req_tdata[2:0]);
      item_in.instr_address = req_tdata[34:3];
      item_in.offset_words  = req_tdata[58:35];
      item_in.absolute      = req_tdata[59];
      item_in.link          = req_tdata[60];
      item_in.bo            = req_tdata[65:61];
      item_in.bi            = req_tdata[70:66];
      item_in.bb            = req_tdata[75:71];
      item_in.logic_op      = logic_op_type'(req_tdata[78:76]);
      item_in.operand_a     = req_tdata[142:79];
      item_in.operand_b     = req_tdata[206:143];
   end

   // Address arithmetic and branch targets.
   logic [32:0] addr_plus4;
   logic [31:0] disp;
   logic [31:0] offset_target;
   logic [31:0] link_target;
   logic [31:0] count_target;

   assign addr_plus4    = {1'b0, item_ff.instr_address} + 33'd4;
   assign disp          = {{6{item_ff.offset_words[23]}}, item_ff.offset_words, 2'b00};
   assign offset_target = item_ff.absolute ? disp : item_ff.instr_address + disp;
   assign link_target   = {link_ff[31:2], 2'b00};
   assign count_target  = {count_ff[31:2], 2'b00};

   // BO rules: optional count decrement tested on its low word, optional bit test.
   logic [63:0] count_dec;
   logic        dec_enable;
   logic        ctr_ok;
   logic        cond_ok;
   logic        branch_ok;
   logic        bit_bi;
   logic        bit_bb;

   assign bit_bi     = cond_ff[5'd31 - item_ff.bi];
   assign bit_bb     = cond_ff[5'd31 - item_ff.bb];
   assign count_dec  = count_ff - 64'd1;
   assign dec_enable = ((item_ff.command == CMD_BC) || (item_ff.command == CMD_BCLR))
                       && !item_ff.bo[BO_NO_DEC];
   assign ctr_ok     = !dec_enable
                       || (item_ff.bo[BO_CTR_ZERO] ? (count_dec[31:0] == 32'd0)
                                                   : (count_dec[31:0] != 32'd0));
   assign cond_ok    = item_ff.bo[BO_NO_COND] || (bit_bi == item_ff.bo[BO_COND_SET]);
   assign branch_ok  = ctr_ok && cond_ok;

   // Trap compares; the word form sign-extends the low words first.
   logic [63:0] trap_a;
   logic [63:0] trap_b;
   logic        trap_hit;
   logic [4:0]  to;

   assign to     = item_ff.bo;
   assign trap_a = (item_ff.command == CMD_TRAP_WORD)
                   ? {{32{item_ff.operand_a[31]}}, item_ff.operand_a[31:0]}
                   : item_ff.operand_a;
   assign trap_b = (item_ff.command == CMD_TRAP_WORD)
                   ? {{32{item_ff.operand_b[31]}}, item_ff.operand_b[31:0]}
                   : item_ff.operand_b;
   assign trap_hit = (to[TO_SLT] && ($signed(trap_a) < $signed(trap_b)))
                     || (to[TO_SGT] && ($signed(trap_b) < $signed(trap_a)))
                     || (to[TO_EQ] && (trap_a == trap_b))
                     || (to[TO_ULT] && (trap_a < trap_b))
                     || (to[TO_UGT] && (trap_a > trap_b));

   // Condition-bit logic result.
   logic cr_result;

   always_comb begin
      case (item_ff.logic_op)
         LOP_AND:  cr_result = bit_bi & bit_bb;
         LOP_ANDC: cr_result = bit_bi & ~bit_bb;
         LOP_EQV:  cr_result = ~(bit_bi ^ bit_bb);
         LOP_NAND: cr_result = ~(bit_bi & bit_bb);
         LOP_NOR:  cr_result = ~(bit_bi | bit_bb);
         LOP_OR:   cr_result = bit_bi | bit_bb;
         LOP_ORC:  cr_result = bit_bi | ~bit_bb;
         LOP_XOR:  cr_result = bit_bi ^ bit_bb;
         default:  cr_result = 1'b0;
      endcase
   end

   // Execute: next register values and the result item.
   logic        taken;
   logic [31:0] target;
   logic        is_branch;

   assign is_branch = (item_ff.command == CMD_BX) || (item_ff.command == CMD_BC)
                      || (item_ff.command == CMD_BCLR) || (item_ff.command == CMD_BCCTR);

   always_comb begin
      taken    = 1'b0;
      target   = offset_target;
      cond_in  = cond_ff;
      count_in = count_ff;
      link_in  = link_ff;
      case (item_ff.command)
         CMD_BX: begin
            taken = 1'b1;
         end
         CMD_BC: begin
            taken = branch_ok;
         end
         CMD_BCLR: begin
            taken  = branch_ok;
            target = link_target;
         end
         CMD_BCCTR: begin
            taken  = branch_ok;
            target = count_target;
         end
         CMD_CR_LOGIC: begin
            cond_in[5'd31 - item_ff.bo] = cr_result;
         end
         CMD_MOVE: begin
            if (item_ff.bb == MOVE_LINK) begin
               link_in = item_ff.operand_a;
            end else if (item_ff.bb == MOVE_COUNT) begin
               count_in = item_ff.operand_a;
            end else if (item_ff.bb == MOVE_COND) begin
               cond_in = item_ff.operand_a[31:0];
            end
         end
         default: begin
            taken = 1'b0;
         end
      endcase
      if (dec_enable) begin
         count_in = count_dec;
      end
      if (is_branch && item_ff.link) begin
         link_in = {31'd0, addr_plus4};
      end
      result_in.taken        = taken;
      result_in.next_address = taken ? target : addr_plus4[31:0];
      result_in.link_value   = link_in;
      result_in.count_value  = count_in;
      result_in.cond_value   = cond_in;
      result_in.trap         = ((item_ff.command == CMD_TRAP_DWORD)
                                || (item_ff.command == CMD_TRAP_WORD)) && trap_hit;
   end

   // Control state and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
         cond_ff         <= 32'd0;
         count_ff        <= 64'd0;
         link_ff         <= 64'd0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
         if (advance) begin
            cond_ff  <= cond_in;
            count_ff <= count_in;
            link_ff  <= link_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // Pack the response transfer.
   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.trap, result_ff.cond_value, result_ff.count_value,
                        result_ff.link_value, result_ff.next_address, result_ff.taken};

endmodule

>>> sim/tb_branch_condition_unit.sv
// Self-checking testbench for branch_condition_unit: directed and random operations
// are streamed in and every result is compared with a built-in predictor.
// Depends on bcu_pkg and the branch_condition_unit RTL.
module tb_branch_condition_unit;
   import bcu_pkg::*;

   // Cycles with no transfer on either side before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_OPS     = 1300;
   // Operations accepted before the receiver starts its long hold-off.
   localparam int HOLD_OFF_AT    = 500;
   localparam int HOLD_OFF_LEN   = 300;

   // Branch option patterns used by the directed part.
   localparam logic [4:0] BO_DEC_NZ_FALSE = 5'b00000;  // decrement, count nonzero, bit clear
   localparam logic [4:0] BO_DEC_ZERO     = 5'b10010;  // ignore bit, decrement, count zero
   localparam logic [4:0] BO_ALWAYS       = 5'b10100;  // neither test
   localparam logic [4:0] BO_BIT_TRUE     = 5'b01100;  // no decrement, bit set
   localparam logic [4:0] BO_BIT_FALSE    = 5'b00110;  // no decrement, bit clear
   localparam logic [4:0] BO_DEC_IGNORE   = 5'b10000;  // decrement requested, bit ignored

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // Predictor copy of the architectural registers.
   logic [31:0] cond_model;
   logic [63:0] count_model;
   logic [63:0] link_model;

   req_item_type pending_ops[$];
   rsp_item_type predicted_results[$];
   req_item_type offered_op;

   int total_ops;
   int ops_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int taken_seen = 0;
   int traps_seen = 0;
   int cmd_count[8];
   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int recv_calm = 0;
   bit hold_off_done = 1'b0;
   bit hold_off_active = 1'b0;
   int idle_cycles;

   branch_condition_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Architectural condition bit n sits at binary position 31-n.
   function automatic logic cond_bit(logic [4:0] n);
      return cond_model[5'd31 - n];
   endfunction

   // BO rules; the count register is decremented here when the rules ask for it.
   function automatic logic branch_allowed(logic [4:0] bo, logic [4:0] bi, logic use_count);
      logic count_ok;
      logic bit_ok;
      logic low_zero;
      count_ok = 1'b1;
      bit_ok = 1'b1;
      if (use_count && !bo[BO_NO_DEC]) begin
         count_model = count_model - 64'd1;
         low_zero = (count_model[31:0] == 32'd0);
         count_ok = bo[BO_CTR_ZERO] ? low_zero : !low_zero;
      end
      if (!bo[BO_NO_COND]) begin
         bit_ok = (cond_bit(bi) == bo[BO_COND_SET]);
      end
      return count_ok && bit_ok;
   endfunction

   function automatic logic trap_hit(logic [63:0] a, logic [63:0] b, logic [4:0] mask);
      return (mask[TO_SLT] && ($signed(a) < $signed(b))) ||
             (mask[TO_SGT] && ($signed(b) < $signed(a))) ||
             (mask[TO_EQ] && (a == b)) ||
             (mask[TO_ULT] && (a < b)) ||
             (mask[TO_UGT] && (a > b));
   endfunction

   // Computes the result of one operation and advances the register copies.
   function automatic rsp_item_type execute_op(req_item_type op);
      rsp_item_type r;
      logic [63:0] fall_through;
      logic [63:0] disp;
      logic [63:0] offset_target;
      logic [63:0] target;
      logic x;
      logic y;
      logic v;
      r = '0;
      fall_through = {32'd0, op.instr_address} + 64'd4;
      disp = {{40{op.offset_words[23]}}, op.offset_words} << 2;
      offset_target = op.absolute ? disp : {32'd0, op.instr_address} + disp;
      target = '0;
      case (op.command)
         CMD_BX: begin
            r.taken = 1'b1;
            target = offset_target;
         end
         CMD_BC: begin
            r.taken = branch_allowed(op.bo, op.bi, 1'b1);
            target = offset_target;
         end
         CMD_BCLR: begin
            // The old link value is the target, even when this op links.
            target = link_model & ~64'd3;
            r.taken = branch_allowed(op.bo, op.bi, 1'b1);
         end
         CMD_BCCTR: begin
            target = count_model & ~64'd3;
            r.taken = branch_allowed(op.bo, op.bi, 1'b0);
         end
         CMD_CR_LOGIC: begin
            x = cond_bit(op.bi);
            y = cond_bit(op.bb);
            case (op.logic_op)
               LOP_AND:  v = x & y;
               LOP_ANDC: v = x & ~y;
               LOP_EQV:  v = ~(x ^ y);
               LOP_NAND: v = ~(x & y);
               LOP_NOR:  v = ~(x | y);
               LOP_OR:   v = x | y;
               LOP_ORC:  v = x | ~y;
               default:  v = x ^ y;
            endcase
            cond_model[5'd31 - op.bo] = v;
         end
         CMD_TRAP_DWORD: begin
            r.trap = trap_hit(op.operand_a, op.operand_b, op.bo);
         end
         CMD_TRAP_WORD: begin
            r.trap = trap_hit({{32{op.operand_a[31]}}, op.operand_a[31:0]},
                              {{32{op.operand_b[31]}}, op.operand_b[31:0]}, op.bo);
         end
         default: begin
            if (op.bb == MOVE_LINK) begin
               link_model = op.operand_a;
            end else if (op.bb == MOVE_COUNT) begin
               count_model = op.operand_a;
            end else if (op.bb == MOVE_COND) begin
               cond_model = op.operand_a[31:0];
            end
         end
      endcase
      if (op.command <= CMD_BCCTR && op.link) begin
         link_model = fall_through;
      end
      r.next_address = r.taken ? target[31:0] : fall_through[31:0];
      r.link_value = link_model;
      r.count_value = count_model;
      r.cond_value = cond_model;
      return r;
   endfunction

   function automatic logic [REQ_DATA_WIDTH-1:0] pack_op(req_item_type op);
      logic [REQ_DATA_WIDTH-1:0] d;
      d = '0;
      d[2:0] = op.command;
      d[34:3] = op.instr_address;
      d[58:35] = op.offset_words;
      d[59] = op.absolute;
      d[60] = op.link;
      d[65:61] = op.bo;
      d[70:66] = op.bi;
      d[75:71] = op.bb;
      d[78:76] = op.logic_op;
      d[142:79] = op.operand_a;
      d[206:143] = op.operand_b;
      return d;
   endfunction

   function automatic req_item_type blank_op(command_type cmd, logic [31:0] addr);
      req_item_type op;
      op = '0;
      op.command = cmd;
      op.instr_address = addr;
      return op;
   endfunction

   // Random operation, weighted so branches see live count and condition values.
   function automatic req_item_type random_op();
      req_item_type op;
      logic [31:0] rnd;
      logic [31:0] imm;
      int unsigned pick;
      rnd = $urandom;
      op.instr_address = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         op.instr_address[1:0] = 2'b00;
      end
      op.offset_words = rnd[23:0];
      rnd = $urandom;
      op.absolute = rnd[0];
      op.link = rnd[1];
      op.bo = rnd[6:2];
      op.bi = rnd[11:7];
      op.bb = rnd[16:12];
      op.logic_op = logic_op_type'(rnd[19:17]);
      op.operand_a = {$urandom, $urandom};
      op.operand_b = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         op.command = CMD_BX;
      end else if (pick < 30) begin
         op.command = CMD_BC;
      end else if (pick < 40) begin
         op.command = CMD_BCLR;
      end else if (pick < 50) begin
         op.command = CMD_BCCTR;
      end else if (pick < 65) begin
         op.command = CMD_CR_LOGIC;
      end else if (pick < 75) begin
         op.command = CMD_TRAP_DWORD;
      end else if (pick < 85) begin
         op.command = CMD_TRAP_WORD;
      end else begin
         op.command = CMD_MOVE;
      end
      // Trap operands: equal, close, a sign-extended immediate, or left random.
      if (op.command == CMD_TRAP_DWORD || op.command == CMD_TRAP_WORD) begin
         imm = $urandom;
         pick = $urandom_range(0, 3);
         if (pick == 0) begin
            op.operand_b = op.operand_a;
         end else if (pick == 1) begin
            op.operand_b = op.operand_a + {{60{imm[3]}}, imm[3:0]};
         end else if (pick == 2) begin
            op.operand_b = {{48{imm[15]}}, imm[15:0]};
         end
      end
      // Moves mostly hit real registers; count writes mostly keep the low word small so that loops end.
      if (op.command == CMD_MOVE) begin
         if ($urandom_range(0, 9) != 0) begin
            op.bb = 5'($urandom_range(0, 2));
         end
         if (op.bb == MOVE_COUNT && $urandom_range(0, 3) != 0) begin
            op.operand_a = {$urandom, 32'($urandom_range(0, 3))};
         end
      end
      return op;
   endfunction

   function automatic int random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Request driver: offers queued operations and predicts each one on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(execute_op(offered_op));
            cmd_count[offered_op.command]++;
            ops_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               offered_op = pending_ops.pop_front();
               req_tdata <= pack_op(offered_op);
               req_tvalid <= 1'b1;
               if (hold_off_active || send_calm > 0) begin
                  if (send_calm > 0) send_calm--;
                  send_gap = 0;
               end else begin
                  send_gap = random_gap();
                  if ($urandom_range(0, 39) == 0) send_calm = 80;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer and drives a randomly stalling ready.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               if (want.taken) taken_seen++;
               if (want.trap) traps_seen++;
               compare_field("taken", 64'(want.taken), 64'(rsp_tdata[0]));
               compare_field("next_address", 64'(want.next_address), 64'(rsp_tdata[32:1]));
               compare_field("link_value", want.link_value, rsp_tdata[96:33]);
               compare_field("count_value", want.count_value, rsp_tdata[160:97]);
               compare_field("cond_value", 64'(want.cond_value), 64'(rsp_tdata[192:161]));
               compare_field("trap", 64'(want.trap), 64'(rsp_tdata[193]));
            end
         end
         // One long hold-off lets the block back up into its input.
         if (!hold_off_done && ops_sent >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_off_active = 1'b1;
            stall_left = HOLD_OFF_LEN;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            hold_off_active = 1'b0;
            rsp_tready <= 1'b1;
            if (recv_calm > 0) begin
               recv_calm--;
            end else begin
               if ($urandom_range(0, 3) == 0) stall_left = random_gap();
               if ($urandom_range(0, 49) == 0) recv_calm = 60;
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("branch_condition_unit: mismatch");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      req_item_type op;
      cond_model = '0;
      count_model = '0;
      link_model = '0;
      for (int i = 0; i < 8; i++) cmd_count[i] = 0;

      // Whole-register writes, including an unused selector.
      op = blank_op(CMD_MOVE, 32'h0000_1000);
      op.bb = MOVE_LINK;
      op.operand_a = 64'hFFFF_FFFF_FFFF_FFFF;
      pending_ops.push_back(op);
      op.bb = MOVE_COUNT;
      op.operand_a = 64'd2;
      pending_ops.push_back(op);
      op.bb = MOVE_COND;
      op.operand_a = 64'hDEAD_BEEF_A5A5_0F0F;
      pending_ops.push_back(op);
      op.bb = 5'd5;
      op.operand_a = 64'h1234_5678_9ABC_DEF0;
      pending_ops.push_back(op);

      // Unconditional branches: wrapping target and a link past 32 bits.
      op = blank_op(CMD_BX, 32'hFFFF_FFFC);
      op.offset_words = 24'h7F_FFFF;
      op.link = 1'b1;
      pending_ops.push_back(op);
      op = blank_op(CMD_BX, 32'h0000_4000);
      op.offset_words = 24'h80_0000;
      op.absolute = 1'b1;
      pending_ops.push_back(op);

      // Conditional branches under the count and bit options.
      op = blank_op(CMD_BC, 32'h0000_2000);
      op.offset_words = 24'hFF_FFF0;
      op.bo = BO_DEC_NZ_FALSE;
      op.bi = 5'd1;
      pending_ops.push_back(op);
      op.bo = BO_DEC_ZERO;
      pending_ops.push_back(op);
      op.bo = BO_ALWAYS;
      op.absolute = 1'b1;
      pending_ops.push_back(op);
      op.bo = BO_BIT_TRUE;
      op.bi = 5'd31;
      op.absolute = 1'b0;
      pending_ops.push_back(op);
      op = blank_op(CMD_BCLR, 32'h0000_3000);
      op.bo = BO_ALWAYS;
      op.link = 1'b1;
      pending_ops.push_back(op);
      op = blank_op(CMD_BCCTR, 32'h0000_3100);
      op.bo = BO_DEC_IGNORE;
      pending_ops.push_back(op);
      op.bo = BO_BIT_FALSE;
      op.bi = 5'd4;
      op.link = 1'b1;
      pending_ops.push_back(op);

      // Count decrement whose low 32 bits reach zero with upper bits set.
      op = blank_op(CMD_MOVE, 32'h0000_5000);
      op.bb = MOVE_COUNT;
      op.operand_a = 64'h0000_0001_0000_0001;
      pending_ops.push_back(op);
      op = blank_op(CMD_BC, 32'h0000_5004);
      op.bo = BO_DEC_ZERO;
      op.offset_words = 24'h00_0010;
      pending_ops.push_back(op);

      // Every condition-bit logic operation, targets at both ends.
      for (int i = 0; i < 8; i++) begin
         op = blank_op(CMD_CR_LOGIC, 32'h0000_6000);
         op.logic_op = logic_op_type'(i[2:0]);
         op.bi = 5'(i * 3);
         op.bb = 5'(31 - i * 2);
         op.bo = i[0] ? 5'd31 : 5'd0;
         pending_ops.push_back(op);
      end

      // Trap compares: full mask, zero mask, word views of wide operands.
      op = blank_op(CMD_TRAP_DWORD, 32'h0000_7000);
      op.bo = 5'd31;
      op.operand_a = 64'h8000_0000_0000_0000;
      op.operand_b = 64'h7FFF_FFFF_FFFF_FFFF;
      pending_ops.push_back(op);
      op.bo = 5'd0;
      pending_ops.push_back(op);
      op = blank_op(CMD_TRAP_WORD, 32'h0000_7100);
      op.bo = 5'd1 << TO_SLT;
      op.operand_a = 64'h0000_0000_8000_0000;
      op.operand_b = 64'hFFFF_FFFF_0000_0001;
      pending_ops.push_back(op);
      op.bo = 5'd1 << TO_EQ;
      op.operand_a = 64'h1234_5678_FFFF_FFFF;
      op.operand_b = 64'hFFFF_FFFF_FFFF_FFFF;
      pending_ops.push_back(op);

      for (int i = 0; i < RANDOM_OPS; i++) begin
         pending_ops.push_back(random_op());
      end
      total_ops = pending_ops.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait (ops_sent == total_ops);
      wait (predicted_results.size() == 0);
      repeat (8) @(posedge clock);

      $display("Ran %0d operations and checked %0d results; %0d branches taken, %0d traps fired.",
               ops_sent, results_seen, taken_seen, traps_seen);
      $display("Per command: bx %0d, bc %0d, bclr %0d, bcctr %0d, cr %0d, td %0d, tw %0d, mv %0d",
               cmd_count[CMD_BX], cmd_count[CMD_BC], cmd_count[CMD_BCLR],
               cmd_count[CMD_BCCTR], cmd_count[CMD_CR_LOGIC], cmd_count[CMD_TRAP_DWORD],
               cmd_count[CMD_TRAP_WORD], cmd_count[CMD_MOVE]);
      if (predicted_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predicted_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("branch_condition_unit: match");
      end else begin
         $display("branch_condition_unit: mismatch");
      end
      $finish;
   end

endmodule
